// ===== rtl/core/tpq_pkg.sv =====
// Shared types, constants and codes for the task priority queue.
`timescale 1ns / 1ps
package tpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int KEY_BITS_DEF    = 8;

  localparam int CFG_BITS    = 5;
  localparam int STATUS_BITS = 2;

  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_RESULT
  } state_t;

  // Write address / data selection for the entry store
  typedef enum logic [1:0] {
    WR_SHIFT_UP,   // slot idx+1 <= slot idx
    WR_SHIFT_DN,   // slot idx-1 <= slot idx
    WR_NEW_NEXT,   // slot idx+1 <= new entry
    WR_NEW_ZERO    // slot 0     <= new entry
  } wr_sel_t;

  typedef struct packed {
    logic    latch;
    logic    idx_inc;
    logic    idx_dec;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_found;
    logic    st_load;
    status_t st_code;
  } dp_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic cnt_zero;
    logic full;
    logic idx_zero;
    logic idx_last;
    logic key_gt;
    logic id_match;
    logic found;
  } dp_stat_t;

endpackage

// ===== rtl/core/tpq_datapath.sv =====
// Entry store, count, capacity register and result registers.
`timescale 1ns / 1ps
module tpq_datapath #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tpq_pkg::ID_BITS_DEF,
  parameter int KEY_BITS    = tpq_pkg::KEY_BITS_DEF,
  localparam int IDX_BITS   = $clog2(QUEUE_DEPTH),
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpq_pkg::dp_cmd_t               cmd,
  output tpq_pkg::dp_stat_t              stat,
  input  logic                           in_func,
  input  logic [ID_BITS-1:0]             in_task_id,
  input  logic [KEY_BITS-1:0]            in_priority_req,
  input  logic                           cfg_wr_en,
  input  logic [tpq_pkg::CFG_BITS-1:0]   cfg_wr_data,
  output logic [tpq_pkg::STATUS_BITS-1:0] out_status,
  output logic                           out_head_valid,
  output logic [ID_BITS-1:0]             out_head_task_id,
  output logic [CNT_BITS-1:0]            out_entry_count
);

  localparam int CMP_BITS = (CNT_BITS > tpq_pkg::CFG_BITS) ? CNT_BITS : tpq_pkg::CFG_BITS;

  logic [ID_BITS-1:0]  slot_id_r  [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] slot_key_r [QUEUE_DEPTH];

  logic [ID_BITS-1:0]          rd_id_r;
  logic [KEY_BITS-1:0]         rd_key_r;
  logic                        func_r;
  logic [ID_BITS-1:0]          id_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [IDX_BITS-1:0]         idx_r, idx_nxt;
  logic [CNT_BITS-1:0]         count_r, count_nxt;
  logic [tpq_pkg::CFG_BITS-1:0] cap_r;
  logic                        found_r;
  tpq_pkg::status_t            status_r;
  logic [ID_BITS-1:0]          head_r;

  logic [CNT_BITS-1:0] cnt_m1;
  logic [IDX_BITS-1:0] wr_addr;
  logic [ID_BITS-1:0]  wr_id;
  logic [KEY_BITS-1:0] wr_key;

  assign cnt_m1 = count_r - CNT_BITS'(1);

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.latch) begin
      idx_nxt = (in_func == tpq_pkg::FUNC_INSERT) ? cnt_m1[IDX_BITS-1:0] : '0;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - IDX_BITS'(1);
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_BITS'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = cnt_m1;
    end
  end

  always_comb begin
    wr_addr = idx_r + IDX_BITS'(1);
    wr_id   = rd_id_r;
    wr_key  = rd_key_r;
    case (cmd.wr_sel)
      tpq_pkg::WR_SHIFT_UP: begin
        wr_addr = idx_r + IDX_BITS'(1);
      end
      tpq_pkg::WR_SHIFT_DN: begin
        wr_addr = idx_r - IDX_BITS'(1);
      end
      tpq_pkg::WR_NEW_NEXT: begin
        wr_addr = idx_r + IDX_BITS'(1);
        wr_id   = id_r;
        wr_key  = key_r;
      end
      tpq_pkg::WR_NEW_ZERO: begin
        wr_addr = '0;
        wr_id   = id_r;
        wr_key  = key_r;
      end
      default: begin
        wr_addr = idx_r + IDX_BITS'(1);
      end
    endcase
  end

  // Entry store: one write, one registered read at the next scan index
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      slot_id_r[wr_addr]  <= wr_id;
      slot_key_r[wr_addr] <= wr_key;
    end
    rd_id_r  <= slot_id_r[idx_nxt];
    rd_key_r <= slot_key_r[idx_nxt];
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      func_r <= in_func;
      id_r   <= in_task_id;
      key_r  <= in_priority_req;
    end
    if (cmd.wr_en && (wr_addr == '0)) begin
      head_r <= wr_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cap_r    <= tpq_pkg::CAP_RESET;
      found_r  <= 1'b0;
      status_r <= tpq_pkg::ST_DONE;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.latch) begin
        found_r <= 1'b0;
      end else if (cmd.set_found) begin
        found_r <= 1'b1;
      end
      if (cmd.st_load) begin
        status_r <= cmd.st_code;
      end
    end
  end

  always_comb begin
    stat.is_remove = (func_r == tpq_pkg::FUNC_REMOVE);
    stat.cnt_zero  = (count_r == '0);
    stat.full      = (CMP_BITS'(count_r) >= CMP_BITS'(cap_r)) ||
                     (count_r >= CNT_BITS'(QUEUE_DEPTH));
    stat.idx_zero  = (idx_r == '0);
    stat.idx_last  = (CNT_BITS'(idx_r) == cnt_m1);
    stat.key_gt    = (rd_key_r > key_r);
    stat.id_match  = (rd_id_r == id_r);
    stat.found     = found_r;
  end

  assign out_status       = status_r;
  assign out_head_valid   = (count_r != '0);
  assign out_head_task_id = (count_r != '0) ? head_r : '0;
  assign out_entry_count  = count_r;

endmodule

// ===== rtl/core/tpq_ctrl.sv =====
// Controller state machine: sequences the scan (with shift), place and result phases.
`timescale 1ns / 1ps
module tpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tpq_pkg::dp_stat_t stat,
  output tpq_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);

  tpq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpq_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = tpq_pkg::S_SCAN;
        end
      end
      tpq_pkg::S_SCAN: begin
        if (stat.is_remove) begin
          if (stat.cnt_zero || stat.idx_last) begin
            state_nxt = tpq_pkg::S_RESULT;
          end
        end else if (stat.full || stat.cnt_zero || !stat.key_gt) begin
          state_nxt = tpq_pkg::S_RESULT;
        end else if (stat.idx_zero) begin
          state_nxt = tpq_pkg::S_PLACE;
        end
      end
      tpq_pkg::S_PLACE:  state_nxt = tpq_pkg::S_RESULT;
      tpq_pkg::S_RESULT: state_nxt = tpq_pkg::S_IDLE;
      default:           state_nxt = tpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = (state_r != tpq_pkg::S_IDLE);
    out_valid = (state_r == tpq_pkg::S_RESULT);
    case (state_r)
      tpq_pkg::S_IDLE: begin
        cmd.latch = start;
      end
      tpq_pkg::S_SCAN: begin
        if (stat.is_remove) begin
          if (stat.cnt_zero) begin
            cmd.st_load = 1'b1;
            cmd.st_code = tpq_pkg::ST_NOT_FOUND;
          end else begin
            // once found, every later slot moves down one
            if (stat.found) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = tpq_pkg::WR_SHIFT_DN;
            end
            cmd.set_found = !stat.found && stat.id_match;
            if (stat.idx_last) begin
              cmd.st_load = 1'b1;
              if (stat.found || stat.id_match) begin
                cmd.cnt_dec = 1'b1;
                cmd.st_code = tpq_pkg::ST_DONE;
              end else begin
                cmd.st_code = tpq_pkg::ST_NOT_FOUND;
              end
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end else if (stat.full) begin
          cmd.st_load = 1'b1;
          cmd.st_code = tpq_pkg::ST_FULL;
        end else if (stat.cnt_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = tpq_pkg::WR_NEW_ZERO;
          cmd.cnt_inc = 1'b1;
          cmd.st_load = 1'b1;
          cmd.st_code = tpq_pkg::ST_DONE;
        end else if (stat.key_gt) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = tpq_pkg::WR_SHIFT_UP;
          cmd.idx_dec = !stat.idx_zero;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = tpq_pkg::WR_NEW_NEXT;
          cmd.cnt_inc = 1'b1;
          cmd.st_load = 1'b1;
          cmd.st_code = tpq_pkg::ST_DONE;
        end
      end
      tpq_pkg::S_PLACE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = tpq_pkg::WR_NEW_ZERO;
        cmd.cnt_inc = 1'b1;
        cmd.st_load = 1'b1;
        cmd.st_code = tpq_pkg::ST_DONE;
      end
      tpq_pkg::S_RESULT: begin
        cmd = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/task_priority_queue_unit.sv =====
// Top level of the task priority queue: controller plus datapath.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  input    | start / busy                | in_func, in_task_id, in_priority_req
//  result   | out_valid (one-cycle strobe)| out_status, out_head_valid,
//           |                             | out_head_task_id, out_entry_count
//  config   | cfg_wr_en                   | cfg_wr_data (capacity limit)
//
// A transfer on the input happens when start is high and busy is low. The entry
// store has one registered read port, so the scan walks one slot per cycle:
// an insert walks from the tail toward the head while it shifts larger keys up,
// a remove walks from the head to the tail and closes the gap behind the match.
// A refused insert, an insert into an empty queue and a remove on an empty queue
// go straight from the scan state to the result state. An insert otherwise scans
// past each slot with a larger key and stops at a smaller or equal key, or goes
// to S_PLACE at the head; a remove scans every entry. busy stays high until the
// cycle after the strobe. Reset (rst_n low, synchronous) empties the queue and
// sets the capacity limit to 16. The result receiver cannot stall the block.
`timescale 1ns / 1ps
module task_priority_queue_unit #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tpq_pkg::ID_BITS_DEF,
  parameter int KEY_BITS    = tpq_pkg::KEY_BITS_DEF,
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transfer
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [ID_BITS-1:0]              in_task_id,
  input  logic [KEY_BITS-1:0]             in_priority_req,
  // configuration write
  input  logic                            cfg_wr_en,
  input  logic [tpq_pkg::CFG_BITS-1:0]    cfg_wr_data,
  // result transfer
  output logic                            out_valid,
  output logic [tpq_pkg::STATUS_BITS-1:0] out_status,
  output logic                            out_head_valid,
  output logic [ID_BITS-1:0]              out_head_task_id,
  output logic [CNT_BITS-1:0]             out_entry_count
);

  tpq_pkg::dp_cmd_t  cmd;
  tpq_pkg::dp_stat_t stat;

  // Sequencer: decides shift, place and finish from datapath flags.
  tpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Entry store, scan index, count, capacity and result fields.
  tpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .KEY_BITS    (KEY_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_task_id       (in_task_id),
    .in_priority_req  (in_priority_req),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_status       (out_status),
    .out_head_valid   (out_head_valid),
    .out_head_task_id (out_head_task_id),
    .out_entry_count  (out_entry_count)
  );

endmodule
